/* hdl/bpa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and sizes for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int NUM_PAGES = 4096;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int CNT_W     = PAGE_W + 1;
  localparam int FILL_W    = PAGE_W + 2;

  localparam logic [CNT_W-1:0] NUM_PAGES_C = CNT_W'(NUM_PAGES);
  localparam logic [CNT_W-1:0] USED_MAX    = '1;
  localparam logic             RESERVED    = 1'b1;  // map fill at reset (1 per entry)

  // operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_MARK  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  // register indexes
  localparam logic REG_USABLE_TOP   = 1'b0;
  localparam logic REG_USABLE_PAGES = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] start_page;
    logic [12:0] page_count;
  } bpa_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] first_page;
    logic [12:0] used_pages;
    logic [12:0] free_pages;
  } bpa_rsp_t;

  typedef enum logic [1:0] {
    KIND_REJECT,
    KIND_ALLOC,
    KIND_RANGE
  } req_kind_t;

  typedef struct packed {
    logic       clr;     // write one reserved entry of the clearing pass
    logic       load;    // take the request
    logic       scan;    // one step of the search
    logic       pass2;   // restart the search from page 0
    logic       fill;    // write one entry of the range
    logic       finish;  // register the result
    logic [1:0] status;
  } bpa_cmd_t;

  typedef struct packed {
    logic      clr_last;
    req_kind_t kind;
    logic      found;
    logic      exhausted;
    logic      second_pass;
    logic      fill_last;
  } bpa_sts_t;

endpackage
`default_nettype wire

/* hdl/bpa_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_datapath
// Page map memory, search counters, accounting and result register.
// ----------------------------------------------------------------------------
module bpa_datapath import bpa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bpa_req_t          in_req,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CNT_W-1:0]  cfg_wdata,
  input  wire bpa_cmd_t          cmd,
  output bpa_sts_t               sts,
  output logic                   out_valid,
  output bpa_rsp_t               out_rsp
);

  logic page_map [NUM_PAGES];

  // control state
  logic [CNT_W-1:0]  usable_top_r, usable_top_nxt;
  logic [CNT_W-1:0]  usable_pages_r, usable_pages_nxt;
  logic [CNT_W-1:0]  hint_r, hint_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [PAGE_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              ev_valid_r, ev_valid_nxt;
  logic              out_valid_r, out_valid_nxt;

  // working registers of one request
  logic [1:0]        op_r, op_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              pass_r, pass_nxt;
  logic [CNT_W-1:0]  issue_pos_r, issue_pos_nxt;
  logic [CNT_W-1:0]  to_r, to_nxt;
  logic [CNT_W-1:0]  old_r, old_nxt;
  logic [PAGE_W-1:0] ev_pos_r, ev_pos_nxt;
  logic [CNT_W-1:0]  run_r, run_nxt;
  logic [PAGE_W-1:0] first_r, first_nxt;
  logic [FILL_W-1:0] fill_pos_r, fill_pos_nxt;
  logic [FILL_W-1:0] fill_end_r, fill_end_nxt;
  logic              fill_val_r, fill_val_nxt;
  bpa_rsp_t          rsp_r, rsp_nxt;
  logic              rd_bit_r;

  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  run_inc;
  logic [CNT_W-1:0]  end_pos;
  logic [CNT_W:0]    used_sum;
  logic [FILL_W-1:0] range_end;
  logic              found;
  req_kind_t         kind;

  logic              mem_we;
  logic [PAGE_W-1:0] mem_waddr;
  logic              mem_wdata;

  assign limit     = (usable_top_r > NUM_PAGES_C) ? NUM_PAGES_C : usable_top_r;
  assign run_inc   = run_r + CNT_W'(1);
  assign end_pos   = {1'b0, ev_pos_r} + CNT_W'(1);
  assign used_sum  = {1'b0, used_r} + {1'b0, count_r};
  assign range_end = FILL_W'(in_req.start_page) + FILL_W'(in_req.page_count);
  assign found     = ev_valid_r && !rd_bit_r && (run_inc == count_r);

  // request classification straight from the input fields
  always_comb begin
    if (in_req.page_count == '0 || in_req.operation == OP_NONE ||
        (in_req.operation == OP_FREE && in_req.start_page == '0)) begin
      kind = KIND_REJECT;
    end else if (in_req.operation == OP_ALLOC) begin
      kind = KIND_ALLOC;
    end else begin
      kind = KIND_RANGE;
    end
  end

  assign sts.kind        = kind;
  assign sts.clr_last    = (clr_cnt_r == '1);
  assign sts.found       = found;
  assign sts.exhausted   = !ev_valid_r && (issue_pos_r >= to_r);
  assign sts.second_pass = pass_r;
  assign sts.fill_last   = ((fill_pos_r + FILL_W'(1)) == fill_end_r);

  always_comb begin
    usable_top_nxt   = usable_top_r;
    usable_pages_nxt = usable_pages_r;
    hint_nxt         = hint_r;
    used_nxt         = used_r;
    clr_cnt_nxt      = clr_cnt_r;
    ev_valid_nxt     = ev_valid_r;
    op_nxt           = op_r;
    count_nxt        = count_r;
    pass_nxt         = pass_r;
    issue_pos_nxt    = issue_pos_r;
    to_nxt           = to_r;
    old_nxt          = old_r;
    ev_pos_nxt       = ev_pos_r;
    run_nxt          = run_r;
    first_nxt        = first_r;
    fill_pos_nxt     = fill_pos_r;
    fill_end_nxt     = fill_end_r;
    fill_val_nxt     = fill_val_r;
    rsp_nxt          = rsp_r;
    out_valid_nxt    = cmd.finish;

    if (cfg_we) begin
      if (cfg_index == REG_USABLE_TOP) begin
        usable_top_nxt = cfg_wdata;
      end else begin
        usable_pages_nxt = cfg_wdata;
      end
    end

    if (cmd.clr) begin
      clr_cnt_nxt = clr_cnt_r + PAGE_W'(1);
    end

    if (cmd.load) begin
      op_nxt        = in_req.operation;
      count_nxt     = in_req.page_count;
      first_nxt     = '0;
      pass_nxt      = 1'b0;
      issue_pos_nxt = hint_r;
      to_nxt        = limit;
      old_nxt       = (hint_r < limit) ? hint_r : limit;
      run_nxt       = '0;
      ev_valid_nxt  = 1'b0;
      fill_pos_nxt  = FILL_W'(in_req.start_page);
      fill_end_nxt  = (range_end > FILL_W'(NUM_PAGES)) ? FILL_W'(NUM_PAGES) : range_end;
      fill_val_nxt  = 1'b0;
      if (kind == KIND_RANGE && in_req.operation == OP_FREE) begin
        if (CNT_W'(in_req.start_page) < hint_r) begin
          hint_nxt = CNT_W'(in_req.start_page);
        end
        used_nxt = (in_req.page_count > used_r) ? '0 : used_r - in_req.page_count;
      end
    end

    if (cmd.scan) begin
      // issue one read a cycle, evaluate the page read the cycle before
      if (issue_pos_r < to_r) begin
        issue_pos_nxt = issue_pos_r + CNT_W'(1);
        ev_pos_nxt    = issue_pos_r[PAGE_W-1:0];
        ev_valid_nxt  = 1'b1;
      end else begin
        ev_valid_nxt  = 1'b0;
      end
      if (ev_valid_r) begin
        run_nxt = rd_bit_r ? '0 : run_inc;
      end
      if (found) begin
        first_nxt    = PAGE_W'(end_pos - count_r);
        fill_pos_nxt = FILL_W'(end_pos - count_r);
        fill_end_nxt = FILL_W'(end_pos);
        fill_val_nxt = 1'b1;
        hint_nxt     = end_pos;
        used_nxt     = used_sum[CNT_W] ? USED_MAX : used_sum[CNT_W-1:0];
      end
    end

    if (cmd.pass2) begin
      pass_nxt      = 1'b1;
      issue_pos_nxt = '0;
      to_nxt        = old_r;
      run_nxt       = '0;
      ev_valid_nxt  = 1'b0;
    end

    if (cmd.fill) begin
      fill_pos_nxt = fill_pos_r + FILL_W'(1);
    end

    if (cmd.finish) begin
      rsp_nxt.status     = cmd.status;
      rsp_nxt.first_page = (cmd.status == ST_OK && op_r == OP_ALLOC) ? first_r : '0;
      rsp_nxt.used_pages = used_r;
      rsp_nxt.free_pages = (usable_pages_r > used_r) ? usable_pages_r - used_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_top_r   <= NUM_PAGES_C;
      usable_pages_r <= NUM_PAGES_C;
      hint_r         <= '0;
      used_r         <= '0;
      clr_cnt_r      <= '0;
      ev_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      usable_top_r   <= usable_top_nxt;
      usable_pages_r <= usable_pages_nxt;
      hint_r         <= hint_nxt;
      used_r         <= used_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      ev_valid_r     <= ev_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    count_r     <= count_nxt;
    pass_r      <= pass_nxt;
    issue_pos_r <= issue_pos_nxt;
    to_r        <= to_nxt;
    old_r       <= old_nxt;
    ev_pos_r    <= ev_pos_nxt;
    run_r       <= run_nxt;
    first_r     <= first_nxt;
    fill_pos_r  <= fill_pos_nxt;
    fill_end_r  <= fill_end_nxt;
    fill_val_r  <= fill_val_nxt;
    rsp_r       <= rsp_nxt;
  end

  // page map: one write port, one registered read port
  assign mem_we    = cmd.clr | cmd.fill;
  assign mem_waddr = cmd.clr ? clr_cnt_r : fill_pos_r[PAGE_W-1:0];
  assign mem_wdata = cmd.clr ? RESERVED : fill_val_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_map[mem_waddr] <= mem_wdata;
    end
    rd_bit_r <= page_map[issue_pos_r[PAGE_W-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

endmodule
`default_nettype wire

/* hdl/bpa_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer: map clearing, search passes, range writes and result strobe.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire bpa_sts_t sts,
  output bpa_cmd_t      cmd,
  output logic          busy
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_REJECT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (sts.kind)
            KIND_ALLOC: state_nxt = S_SCAN;
            KIND_RANGE: state_nxt = S_FILL;
            default:    state_nxt = S_REJECT;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          state_nxt = S_FILL;
        end else if (sts.exhausted) begin
          if (!sts.second_pass) begin
            cmd.pass2 = 1'b1;
          end else begin
            cmd.finish = 1'b1;
            cmd.status = ST_OOM;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.fill_last) begin
          cmd.finish = 1'b1;
          cmd.status = ST_OK;
          state_nxt  = S_IDLE;
        end
      end
      S_REJECT: begin
        cmd.finish = 1'b1;
        cmd.status = ST_IGNORED;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule
`default_nettype wire

/* hdl/bitmap_page_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Next-fit physical page allocator over a one-bit-per-page map.
// ----------------------------------------------------------------------------
//
//  channel   ports                               handshake
//  --------  ----------------------------------  ---------------------------
//  request   start, busy, in_req                 taken when start & !busy
//  result    out_valid, out_rsp                  one-cycle strobe, no stall
//  config    cfg_we, cfg_index, cfg_wdata        written when cfg_we
//
//  One request at a time. After reset the map is filled with "reserved"
//  one entry a cycle, with busy high until that pass is done.
//  Allocate: take the request, then examine one page a cycle (single read
//  port of the map) from the hint up to the limit and, if that comes up
//  empty, from page 0 up to the old hint; then mark the run one page a
//  cycle. Out of memory ends after the second pass. Free / mark usable:
//  take the request, then write the range (clipped at the map end) one
//  page a cycle. Rejected requests: take the request, then finish. The
//  result strobe comes the cycle after the last step, busy drops with it.
//
// ----------------------------------------------------------------------------
module bitmap_page_allocator import bpa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request
  input  wire logic              start,
  output logic                   busy,
  input  wire bpa_req_t          in_req,
  // result
  output logic                   out_valid,
  output bpa_rsp_t               out_rsp,
  // configuration: 0 usable_top, 1 usable_pages
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CNT_W-1:0]  cfg_wdata
);

  bpa_cmd_t cmd;
  bpa_sts_t sts;

  // sequencer: clearing pass, search passes, range writes
  bpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // map memory, search pointer / run counter, hint and used count
  bpa_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmap page allocator. A behavioral copy of the
// page map, search hint and used count predicts every response; responses
// are compared field by field in arrival order. Directed requests cover the
// reserved map, next-fit wrap, limits and count saturation, then random
// traffic runs under several register settings and sender idle rates.
// ----------------------------------------------------------------------------
module testbench;
  import bpa_pkg::*;

  // generous: worst case is a full scan plus a full-map mark per request,
  // times ~140 requests, plus the clearing pass after reset
  localparam int CYCLE_LIMIT = 8_000_000;

  logic            clk;
  logic            rst_n     = 1'b0;
  logic            start     = 1'b0;
  logic            busy;
  bpa_req_t        in_req    = '0;
  logic            out_valid;
  bpa_rsp_t        out_rsp;
  logic            cfg_we    = 1'b0;
  logic            cfg_index = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  bitmap_page_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 2 ns period
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // --------------------------------------------------------------------------
  // Allocator shadow state: one bit per page (1 = reserved/used), the next-fit
  // hint, the used counter and both registers, all at their reset values.
  // --------------------------------------------------------------------------
  bit page_taken [NUM_PAGES];
  int next_hint    = 0;
  int pages_in_use = 0;
  int top_reg      = 4096;
  int usable_reg   = 4096;

  bpa_rsp_t awaited_rsp [$];   // responses still owed by the block, oldest first
  int       run_first [$];     // runs handed out, used to build sensible frees
  int       run_len [$];

  int idle_pct   = 0;
  int mismatches = 0;
  int cycles     = 0;
  int n_alloc = 0, n_oom = 0, n_free = 0, n_mark = 0, n_rejected = 0;

  initial begin
    foreach (page_taken[i]) page_taken[i] = 1'b1;
  end

  // Look in [from_pg, to_pg) for cnt free pages in a row; the run counter
  // starts over for every pass. On a hit the run is taken.
  function automatic bit claim_run(input int from_pg, input int to_pg, input int cnt,
                                   output int first_pg, output int end_pg);
    int run;
    int pos;
    int k;
    run = 0;
    first_pg = 0;
    end_pg = 0;
    for (pos = from_pg; pos < to_pg; pos++) begin
      if (!page_taken[pos]) begin
        run++;
        if (run == cnt) begin
          first_pg = pos + 1 - cnt;
          for (k = first_pg; k <= pos; k++) page_taken[k] = 1'b1;
          end_pg = pos + 1;
          return 1'b1;
        end
      end else begin
        run = 0;
      end
    end
    return 1'b0;
  endfunction

  // pages past the end of the map are left alone
  function automatic void release_range(input int first_pg, input int cnt);
    int k;
    for (k = 0; k < cnt; k++) begin
      if (first_pg + k >= NUM_PAGES) break;
      page_taken[first_pg + k] = 1'b0;
    end
  endfunction

  // Apply one request to the shadow state and return the response it owes.
  function automatic bpa_rsp_t predict_response(input bpa_req_t r);
    bpa_rsp_t rsp;
    int cnt;
    int pg;
    int lim;
    int old_hint;
    int first_pg;
    int end_pg;
    bit found;
    cnt = r.page_count;
    pg = r.start_page;
    first_pg = 0;
    rsp.status = ST_OK;
    if (cnt == 0 || r.operation == OP_NONE) begin
      rsp.status = ST_IGNORED;
    end else if (r.operation == OP_ALLOC) begin
      // search limit is usable_top clipped to the map; the wrap pass stops at
      // the old hint clipped to that limit
      lim = (top_reg < NUM_PAGES) ? top_reg : NUM_PAGES;
      old_hint = (next_hint < lim) ? next_hint : lim;
      found = claim_run(next_hint, lim, cnt, first_pg, end_pg);
      if (!found) found = claim_run(0, old_hint, cnt, first_pg, end_pg);
      if (found) begin
        next_hint = end_pg;
        pages_in_use = (pages_in_use + cnt > int'(USED_MAX)) ? int'(USED_MAX)
                                                            : pages_in_use + cnt;
      end else begin
        rsp.status = ST_OOM;
        first_pg = 0;
      end
    end else if (r.operation == OP_FREE) begin
      if (pg == 0) begin
        rsp.status = ST_IGNORED;
      end else begin
        release_range(pg, cnt);
        if (pg < next_hint) next_hint = pg;
        pages_in_use = (cnt > pages_in_use) ? 0 : pages_in_use - cnt;
      end
    end else begin
      release_range(pg, cnt);
    end
    rsp.first_page = PAGE_W'(first_pg);
    rsp.used_pages = CNT_W'(pages_in_use);
    rsp.free_pages = CNT_W'((usable_reg > pages_in_use) ? usable_reg - pages_in_use : 0);
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Drive on the falling edge, take the request as accepted at
  // the first rising edge with busy low. start is left high on return; the
  // next call overwrites the request, an idle gap or a drain lowers it.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] op, input int pg, input int cnt);
    bpa_req_t req;
    bpa_rsp_t rsp;
    req.operation  = op;
    req.start_page = pg[PAGE_W-1:0];
    req.page_count = cnt[CNT_W-1:0];
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    @(negedge clk);
    in_req <= req;
    start  <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    rsp = predict_response(req);
    awaited_rsp.push_back(rsp);
    if (rsp.status == ST_IGNORED) begin
      n_rejected++;
    end else if (op == OP_ALLOC) begin
      n_alloc++;
      if (rsp.status == ST_OOM) begin
        n_oom++;
      end else begin
        run_first.push_back(rsp.first_page);
        run_len.push_back(cnt);
      end
    end else if (op == OP_FREE) begin
      n_free++;
    end else begin
      n_mark++;
    end
  endtask

  // hold requests off until every owed response has come back
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic cfg_write(input logic idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CNT_W-1:0];
    @(posedge clk);
    if (idx == REG_USABLE_TOP) top_reg = val;
    else usable_reg = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Response side: every strobe must match the oldest owed response.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int exp_v, input int act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin : check_responses
    bpa_rsp_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (awaited_rsp.size() == 0) begin
        report_mismatch("response with no request pending", 0, 1);
      end else begin
        want = awaited_rsp.pop_front();
        if (out_rsp.status !== want.status)
          report_mismatch("status", want.status, out_rsp.status);
        if (out_rsp.first_page !== want.first_page)
          report_mismatch("first_page", want.first_page, out_rsp.first_page);
        if (out_rsp.used_pages !== want.used_pages)
          report_mismatch("used_pages", want.used_pages, out_rsp.used_pages);
        if (out_rsp.free_pages !== want.free_pages)
          report_mismatch("free_pages", want.free_pages, out_rsp.free_pages);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles,
               awaited_rsp.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Map is fully reserved after reset: allocation fails after both passes,
  // zero counts, unknown ops and free of page zero are all rejected.
  task automatic test_reserved_map;
    send_request(OP_ALLOC, 0, 1);
    send_request(OP_ALLOC, 0, 0);
    send_request(OP_FREE, 5, 0);
    send_request(OP_MARK, 0, 0);
    send_request(OP_NONE, 4095, 8191);
    send_request(OP_FREE, 0, 3);
  endtask

  // Small 64-page window: next-fit order, hint pulled back by free, out of
  // memory with both passes failing, and a hit found only on the wrap pass.
  task automatic test_next_fit;
    drain;
    cfg_write(REG_USABLE_TOP, 64);
    cfg_write(REG_USABLE_PAGES, 64);
    send_request(OP_MARK, 0, 64);
    send_request(OP_ALLOC, 0, 10);
    send_request(OP_ALLOC, 0, 20);
    send_request(OP_FREE, 4, 3);
    send_request(OP_ALLOC, 0, 2);
    send_request(OP_ALLOC, 0, 30);
    send_request(OP_ALLOC, 0, 5);   // 4 free at the top, 1 below: no fit
    send_request(OP_MARK, 20, 5);   // hole below the hint, count untouched
    send_request(OP_ALLOC, 0, 5);   // lands in the hole via the wrap pass
  endtask

  // Limit above the map, ranges running off the end, hint past the limit,
  // free larger than the used count, oversized allocation, zero limit.
  task automatic test_map_limits;
    drain;
    cfg_write(REG_USABLE_TOP, 8191);
    send_request(OP_MARK, 4000, 200);
    send_request(OP_ALLOC, 0, 96);
    send_request(OP_ALLOC, 0, 1);    // hint at the map end, wrap pass only
    send_request(OP_FREE, 1, 8191);  // used count floors at zero
    send_request(OP_ALLOC, 0, 8191);
    drain;
    cfg_write(REG_USABLE_TOP, 0);
    cfg_write(REG_USABLE_PAGES, 0);
    send_request(OP_ALLOC, 0, 1);
  endtask

  // Used count climbs past the map size by re-marking taken pages usable,
  // then saturates; free count floors at zero until usable_pages is raised.
  task automatic test_used_saturation;
    drain;
    cfg_write(REG_USABLE_TOP, 4096);
    cfg_write(REG_USABLE_PAGES, 4096);
    send_request(OP_MARK, 0, 4096);
    send_request(OP_ALLOC, 0, 4095);
    send_request(OP_MARK, 0, 4096);
    send_request(OP_ALLOC, 0, 4096);
    send_request(OP_MARK, 0, 1);
    send_request(OP_ALLOC, 0, 1);
    drain;
    cfg_write(REG_USABLE_PAGES, 8191);
    send_request(OP_FREE, 4000, 96);
  endtask

  // Random traffic inside a freshly released window: mostly allocations and
  // frees of runs that were handed out, some re-marking and some requests
  // the block must reject. One full drain in the middle of each phase.
  task automatic test_random_traffic(input int pct, input int top_val, input int pages_val,
                                     input int n_req);
    int done;
    int lim;
    int k;
    int pg;
    int len;
    int off;
    int cnt;
    int pick;
    bit drained;
    done = 0;
    drained = 1'b0;
    drain;
    cfg_write(REG_USABLE_TOP, top_val);
    cfg_write(REG_USABLE_PAGES, pages_val);
    lim = (top_val < NUM_PAGES) ? top_val : NUM_PAGES;
    run_first.delete();
    run_len.delete();
    idle_pct = pct;
    send_request(OP_MARK, 0, lim);
    while (done < n_req) begin
      if (!drained && done == n_req / 2) begin
        drain;
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // mostly small runs, now and then a big one
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, lim / 2 + 1)
                                          : $urandom_range(1, 12);
        send_request(OP_ALLOC, $urandom_range(0, 4095), cnt);
        done++;
      end else if (pick < 75) begin
        if (run_first.size() != 0) begin
          k = $urandom_range(0, run_first.size() - 1);
          pg = run_first[k];
          len = run_len[k];
          run_first.delete(k);
          run_len.delete(k);
          cnt = len;
          if ($urandom_range(0, 4) == 0) begin
            off = $urandom_range(0, len - 1);
            pg += off;
            cnt = $urandom_range(1, len - off);
          end
        end else begin
          pg = $urandom_range(1, lim - 1);
          cnt = $urandom_range(1, 16);
        end
        send_request(OP_FREE, pg, cnt);
        done++;
      end else if (pick < 85) begin
        send_request(OP_MARK, $urandom_range(0, lim - 1), $urandom_range(1, 16));
        done++;
      end else begin
        // rejected requests: cheap, not counted toward the phase length
        case ($urandom_range(0, 2))
          0: send_request(OP_NONE, $urandom_range(0, 4095), $urandom_range(0, 8191));
          1: send_request(2'($urandom_range(0, 3)), $urandom_range(0, 4095), 0);
          default: send_request(OP_FREE, 0, $urandom_range(0, 8191));
        endcase
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // the first request waits out the clearing pass through busy
    test_reserved_map;
    test_next_fit;
    test_map_limits;
    test_used_saturation;

    test_random_traffic(0, 256, 256, 30);
    test_random_traffic(45, 64, 80, 30);
    test_random_traffic(17, 4096, 4096, 10);
    test_random_traffic(0, 200, 100, 20);

    drain;
    repeat (64) @(posedge clk);   // catch any stray strobe
    if (awaited_rsp.size() != 0)
      report_mismatch("responses never returned", 0, awaited_rsp.size());

    $display("Ran %0d allocations (%0d out of memory), %0d frees, %0d range releases,",
             n_alloc, n_oom, n_free, n_mark);
    $display("%0d rejected requests over several register settings; %0d mismatches",
             n_rejected, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
